[hdl/text_console_buffer_assert.svh]
// ----------------------------------------------------------------------------
// Text console buffer assertion macros
// Shared forms for the concurrent assertions of the console buffer checker.
// ----------------------------------------------------------------------------
`ifndef TEXT_CONSOLE_BUFFER_ASSERT_SVH
`define TEXT_CONSOLE_BUFFER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TCB_ASSERT_HOLDS(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TCB_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/tcb_pkg.sv]
// ----------------------------------------------------------------------------
// Text console buffer package
// Field widths, default grid size, operation and character codes and the
// sequencer state type of the console buffer.
// ----------------------------------------------------------------------------
package tcb_pkg;

    localparam int OPCODE_W = 2;
    localparam int CHAR_W   = 8;
    localparam int RROW_W   = 4;
    localparam int RCOL_W   = 5;
    localparam int COLNOW_W = 5;
    localparam int ROWNOW_W = 4;

    localparam int COLS_DEF = 21;
    localparam int ROWS_DEF = 10;

    localparam logic [OPCODE_W-1:0] OP_LETTER = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_CLEAR  = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_READ   = 2'd2;

    localparam logic [CHAR_W-1:0] CODE_NUL        = 8'd0;
    localparam logic [CHAR_W-1:0] CODE_BACKSPACE  = 8'd8;
    localparam logic [CHAR_W-1:0] CODE_LINEFEED   = 8'd10;
    localparam logic [CHAR_W-1:0] CODE_OPEN_PAREN = 8'd40;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_EXEC,
        S_SCROLL,
        S_BS_SCAN,
        S_BS_READ,
        S_BS_FIN,
        S_RD_WAIT,
        S_DONE
    } t_state;

endpackage

[hdl/tcb_if.sv]
// ----------------------------------------------------------------------------
// Text console buffer channels
// Valid/ready channels for the command items and the result items.
// ----------------------------------------------------------------------------
interface tcb_in_if;
    import tcb_pkg::*;

    logic                valid;
    logic                ready;
    logic [OPCODE_W-1:0] opcode;
    logic [CHAR_W-1:0]   char_code;
    logic [RROW_W-1:0]   read_row;
    logic [RCOL_W-1:0]   read_col;

    modport source (output valid, output opcode, output char_code, output read_row,
                    output read_col, input ready);
    modport sink   (input valid, input opcode, input char_code, input read_row,
                    input read_col, output ready);
endinterface

interface tcb_out_if;
    import tcb_pkg::*;

    logic                valid;
    logic                ready;
    logic [COLNOW_W-1:0] col_now;
    logic [ROWNOW_W-1:0] row_now;
    logic [CHAR_W-1:0]   read_char;
    logic                scrolled;
    logic                paren_erased;

    modport source (output valid, output col_now, output row_now, output read_char,
                    output scrolled, output paren_erased, input ready);
    modport sink   (input valid, input col_now, input row_now, input read_char,
                    input scrolled, input paren_erased, output ready);
endinterface

[hdl/tcb_ram.sv]
// ----------------------------------------------------------------------------
// Text console buffer RAM
// Generic memory with one write port and one read port with registered data.
// ----------------------------------------------------------------------------
module tcb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

[hdl/text_console_buffer.sv]
// ----------------------------------------------------------------------------
// Text console buffer
// Character grid with a cursor, held in one RAM and driven by a sequencer.
// ----------------------------------------------------------------------------
// One item is taken at a time; ready is high only while the sequencer waits
// for work, and a finished result waits in the output register while the next
// item is taken. A scroll also clears the new bottom row, a backspace from
// column zero first searches the previous row for its last character, and a
// clear item sweeps all ROWS*COLS cells, one per cycle. After reset the same
// sweep runs before the first item is taken. These steps run one after
// another on the single RAM port pair.
module text_console_buffer #(
    parameter int COLS = tcb_pkg::COLS_DEF,
    parameter int ROWS = tcb_pkg::ROWS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    tcb_in_if.sink    i_in,
    tcb_out_if.source o_out
);
    import tcb_pkg::*;

    localparam int CW    = $clog2(COLS);
    localparam int RW    = $clog2(ROWS);
    localparam int PW    = RW + 1;
    localparam int CELLS = ROWS * COLS;
    localparam int AW    = $clog2(CELLS);

    t_state r_state, n_state;

    logic [CW-1:0] r_col, n_col;
    logic [RW-1:0] r_row, n_row;
    logic [RW-1:0] r_top, n_top;
    logic [AW-1:0] r_sweep, n_sweep;
    logic [CW-1:0] r_scan_col, n_scan_col;
    logic [CW-1:0] r_chk_col, n_chk_col;
    logic          r_chk_vld, n_chk_vld;
    logic          r_clr_item, n_clr_item;

    logic [OPCODE_W-1:0] r_op, n_op;
    logic [CHAR_W-1:0]   r_code, n_code;
    logic [RROW_W-1:0]   r_rrow, n_rrow;
    logic [RCOL_W-1:0]   r_rcol, n_rcol;
    logic [CHAR_W-1:0]   r_rchar, n_rchar;
    logic                r_scr, n_scr;
    logic                r_par, n_par;

    logic                r_ov;
    logic [COLNOW_W-1:0] r_o_col;
    logic [ROWNOW_W-1:0] r_o_row;
    logic [CHAR_W-1:0]   r_o_char;
    logic                r_o_scr;
    logic                r_o_par;
    logic                load_out;

    logic [RW-1:0] a_row;
    logic [CW-1:0] a_col;
    logic [PW-1:0] phys_sum;
    logic [RW-1:0] phys;
    logic [AW-1:0] cell_addr;

    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    logic [CHAR_W-1:0] wr_data;
    logic              rd_en;
    logic [AW-1:0]     rd_addr;
    logic [CHAR_W-1:0] rd_data;
    logic              lf_go;

    tcb_ram #(
        .WIDTH (CHAR_W),
        .DEPTH (CELLS)
    ) u_cells (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // Screen row to physical row through the rotating top-row index.
    always_comb begin
        phys_sum  = {1'b0, r_top} + {1'b0, a_row};
        phys      = (phys_sum >= PW'(ROWS)) ? RW'(phys_sum - PW'(ROWS)) : RW'(phys_sum);
        cell_addr = AW'(AW'(phys) * AW'(COLS)) + AW'(a_col);
    end

    assign i_in.ready = (r_state == S_IDLE);

    always_comb begin
        n_state    = r_state;
        n_col      = r_col;
        n_row      = r_row;
        n_top      = r_top;
        n_sweep    = r_sweep;
        n_scan_col = r_scan_col;
        n_chk_col  = r_chk_col;
        n_chk_vld  = r_chk_vld;
        n_clr_item = r_clr_item;
        n_op       = r_op;
        n_code     = r_code;
        n_rrow     = r_rrow;
        n_rcol     = r_rcol;
        n_rchar    = r_rchar;
        n_scr      = r_scr;
        n_par      = r_par;
        a_row      = r_row;
        a_col      = r_col;
        wr_en      = 1'b0;
        wr_addr    = cell_addr;
        wr_data    = CODE_NUL;
        rd_en      = 1'b0;
        rd_addr    = cell_addr;
        load_out   = 1'b0;
        lf_go      = 1'b0;

        case (r_state)
            S_CLEAR: begin
                wr_en   = 1'b1;
                wr_addr = r_sweep;
                if (r_sweep == AW'(CELLS - 1)) begin
                    n_state = r_clr_item ? S_DONE : S_IDLE;
                end else begin
                    n_sweep = r_sweep + 1'b1;
                end
            end
            S_IDLE: begin
                if (i_in.valid) begin
                    n_op       = i_in.opcode;
                    n_code     = i_in.char_code;
                    n_rrow     = i_in.read_row;
                    n_rcol     = i_in.read_col;
                    n_rchar    = CODE_NUL;
                    n_scr      = 1'b0;
                    n_par      = 1'b0;
                    n_clr_item = 1'b0;
                    n_state    = S_EXEC;
                end
            end
            S_EXEC: begin
                case (r_op)
                    OP_LETTER: begin
                        if (r_code == CODE_BACKSPACE) begin
                            if (r_col != '0) begin
                                n_col   = r_col - 1'b1;
                                n_state = S_BS_READ;
                            end else if (r_row != '0) begin
                                n_row      = r_row - 1'b1;
                                n_scan_col = CW'(COLS - 1);
                                n_chk_vld  = 1'b0;
                                n_state    = S_BS_SCAN;
                            end else begin
                                n_state = S_BS_READ;
                            end
                        end else if (r_code == CODE_LINEFEED) begin
                            lf_go = 1'b1;
                        end else begin
                            wr_en   = 1'b1;
                            wr_data = r_code;
                            if (r_col == CW'(COLS - 1)) begin
                                lf_go = 1'b1;
                            end else begin
                                n_col   = r_col + 1'b1;
                                n_state = S_DONE;
                            end
                        end
                    end
                    OP_CLEAR: begin
                        n_col      = '0;
                        n_row      = '0;
                        n_top      = '0;
                        n_sweep    = '0;
                        n_clr_item = 1'b1;
                        n_state    = S_CLEAR;
                    end
                    OP_READ: begin
                        a_row = RW'(r_rrow);
                        a_col = CW'(r_rcol);
                        if ((int'(r_rrow) < ROWS) && (int'(r_rcol) < COLS)) begin
                            rd_en   = 1'b1;
                            n_state = S_RD_WAIT;
                        end else begin
                            n_state = S_DONE;
                        end
                    end
                    default: begin
                        n_state = S_DONE;
                    end
                endcase
            end
            S_SCROLL: begin
                // With the top index already advanced, the bottom screen row is
                // the physical row that has just left the top.
                a_row = RW'(ROWS - 1);
                a_col = r_scan_col;
                wr_en = 1'b1;
                if (r_scan_col == CW'(COLS - 1)) begin
                    n_state = S_DONE;
                end else begin
                    n_scan_col = r_scan_col + 1'b1;
                end
            end
            S_BS_SCAN: begin
                // Reads are issued one per cycle; each result is checked in the cycle after its read.
                a_col      = r_scan_col;
                rd_en      = 1'b1;
                n_scan_col = r_scan_col - 1'b1;
                n_chk_col  = r_scan_col;
                n_chk_vld  = 1'b1;
                if (r_chk_vld) begin
                    if (rd_data != CODE_NUL) begin
                        n_col   = r_chk_col;
                        n_state = S_BS_READ;
                    end else if (r_chk_col == CW'(1)) begin
                        n_col   = '0;
                        n_state = S_BS_READ;
                    end
                end
            end
            S_BS_READ: begin
                rd_en   = 1'b1;
                n_state = S_BS_FIN;
            end
            S_BS_FIN: begin
                n_par   = (rd_data == CODE_OPEN_PAREN);
                wr_en   = 1'b1;
                n_state = S_DONE;
            end
            S_RD_WAIT: begin
                n_rchar = rd_data;
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_ov || o_out.ready) begin
                    load_out = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (lf_go) begin
            n_col = '0;
            if (r_row == RW'(ROWS - 1)) begin
                n_top      = (r_top == RW'(ROWS - 1)) ? '0 : r_top + 1'b1;
                n_scr      = 1'b1;
                n_scan_col = '0;
                n_state    = S_SCROLL;
            end else begin
                n_row   = r_row + 1'b1;
                n_state = S_DONE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_col      <= '0;
            r_row      <= '0;
            r_top      <= '0;
            r_sweep    <= '0;
            r_scan_col <= '0;
            r_chk_col  <= '0;
            r_chk_vld  <= 1'b0;
            r_clr_item <= 1'b0;
            r_ov       <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_col      <= n_col;
            r_row      <= n_row;
            r_top      <= n_top;
            r_sweep    <= n_sweep;
            r_scan_col <= n_scan_col;
            r_chk_col  <= n_chk_col;
            r_chk_vld  <= n_chk_vld;
            r_clr_item <= n_clr_item;
            if (load_out) begin
                r_ov <= 1'b1;
            end else if (o_out.ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_op    <= n_op;
        r_code  <= n_code;
        r_rrow  <= n_rrow;
        r_rcol  <= n_rcol;
        r_rchar <= n_rchar;
        r_scr   <= n_scr;
        r_par   <= n_par;
        if (load_out) begin
            r_o_col  <= COLNOW_W'(r_col);
            r_o_row  <= ROWNOW_W'(r_row);
            r_o_char <= r_rchar;
            r_o_scr  <= r_scr;
            r_o_par  <= r_par;
        end
    end

    assign o_out.valid        = r_ov;
    assign o_out.col_now      = r_o_col;
    assign o_out.row_now      = r_o_row;
    assign o_out.read_char    = r_o_char;
    assign o_out.scrolled     = r_o_scr;
    assign o_out.paren_erased = r_o_par;

endmodule

[hdl/tcb_checker.sv]
// ----------------------------------------------------------------------------
// Text console buffer checker
// Port-level assertions on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`include "text_console_buffer_assert.svh"

module tcb_checker #(
    parameter int COLS = tcb_pkg::COLS_DEF,
    parameter int ROWS = tcb_pkg::ROWS_DEF
) (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_out_valid,
    input logic                         i_out_ready,
    input logic [tcb_pkg::COLNOW_W-1:0] i_out_col_now,
    input logic [tcb_pkg::ROWNOW_W-1:0] i_out_row_now,
    input logic                         i_out_scrolled,
    input logic                         i_out_paren_erased
);
    import tcb_pkg::*;

    // A scroll and an erase never come from the same item.
    `TCB_ASSERT_HOLDS(a_flags_exclusive, i_clk, i_rst_n, i_out_valid, !(i_out_scrolled && i_out_paren_erased), "scrolled and paren_erased both set")

    // After a scroll the cursor sits at the start of the bottom row.
    `TCB_ASSERT_HOLDS(a_scroll_cursor, i_clk, i_rst_n, i_out_valid && i_out_scrolled, (i_out_col_now == '0) && (ROWS > 16 || i_out_row_now == ROWNOW_W'(ROWS - 1)), "cursor not at bottom row start after scroll")

    // The cursor row never leaves the grid.
    `TCB_ASSERT_HOLDS(a_row_range, i_clk, i_rst_n, i_out_valid, (ROWS > 16) || (int'(i_out_row_now) < ROWS), "cursor row outside the grid")

    // A result that is not taken stays offered.
    `TCB_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid, "result withdrawn before it was taken")

endmodule

bind text_console_buffer tcb_checker #(
    .COLS (COLS),
    .ROWS (ROWS)
) u_tcb_checker (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .i_out_valid        (o_out.valid),
    .i_out_ready        (o_out.ready),
    .i_out_col_now      (o_out.col_now),
    .i_out_row_now      (o_out.row_now),
    .i_out_scrolled     (o_out.scrolled),
    .i_out_paren_erased (o_out.paren_erased)
);
